>>> rtl/setq_pkg.sv
// Package for the sorted expiry timer queue: entry and command types,
// operation codes, status codes and field widths. No dependencies.
`default_nettype none

package setq_pkg;

    localparam int FUNC_W   = 2;
    localparam int ID_W     = 8;
    localparam int TIME_W   = 32;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 3;

    // Most timers a single tick may pop.
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = $clog2(RESULT_LIMIT);

    // Request operations.
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADJUST = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd3;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXPIRED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd5;

    // Commands broadcast to the row of cells.
    localparam logic [1:0] CMD_HOLD   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_POP    = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] expire;
        logic [ID_W-1:0]   id;
        logic [PAY_W-1:0]  payload;
    } entry_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] expire;
        logic [ID_W-1:0]   id;
        logic [PAY_W-1:0]  payload;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/setq_req_if.sv
// Request channel of the timer queue: valid/ready handshake and operation fields.
// Depends on setq_pkg for the field widths.
`default_nettype none

interface setq_req_if import setq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] expire_time;
    logic [PAY_W-1:0]  payload;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, func, timer_id, expire_time, payload, now_time,
                    input ready);
    modport sink   (input valid, func, timer_id, expire_time, payload, now_time,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/setq_rsp_if.sv
// Response channel of the timer queue: valid/ready handshake and result fields.
// Depends on setq_pkg for the field widths.
`default_nettype none

interface setq_rsp_if import setq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_timer_id;
    logic [PAY_W-1:0]    out_payload;
    logic [TIME_W-1:0]   out_expire;
    logic                last;

    modport source (output valid, status, out_timer_id, out_payload, out_expire, last,
                    input ready);
    modport sink   (input valid, status, out_timer_id, out_payload, out_expire, last,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/setq_cell.sv
// One slot of the sorted timer row. Holds one entry and trades it with its
// neighbors under the broadcast command. Depends on setq_pkg.
`default_nettype none

module setq_cell import setq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cmd_t   cmd,
    input  wire entry_t left,
    input  wire logic   left_le,
    input  wire logic   found_in,
    input  wire entry_t right,
    output entry_t      cur,
    output logic        le,
    output logic        match,
    output logic        found_out
);

    logic              valid_reg;
    logic              valid_next;
    logic [TIME_W-1:0] expire_reg;
    logic [TIME_W-1:0] expire_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic [PAY_W-1:0]  payload_reg;
    logic [PAY_W-1:0]  payload_next;

    assign cur = {valid_reg, expire_reg, id_reg, payload_reg};

    // The row stays sorted, so the cells with le set form a prefix.
    assign le        = valid_reg && (expire_reg <= cmd.expire);
    assign match     = valid_reg && (id_reg == cmd.id);
    assign found_out = found_in || match;

    always_comb
    begin
        valid_next   = valid_reg;
        expire_next  = expire_reg;
        id_next      = id_reg;
        payload_next = payload_reg;
        case (cmd.op)
            CMD_INSERT:
            begin
                if (!left_le)
                begin
                    valid_next   = left.valid;
                    expire_next  = left.expire;
                    id_next      = left.id;
                    payload_next = left.payload;
                end
                else if (!le)
                begin
                    // First slot past every entry due no later than the new one.
                    valid_next   = 1'b1;
                    expire_next  = cmd.expire;
                    id_next      = cmd.id;
                    payload_next = cmd.payload;
                end
            end
            CMD_REMOVE, CMD_POP:
            begin
                if (found_out || (cmd.op == CMD_POP))
                begin
                    valid_next   = right.valid;
                    expire_next  = right.expire;
                    id_next      = right.id;
                    payload_next = right.payload;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        expire_reg  <= expire_next;
        id_reg      <= id_next;
        payload_reg <= payload_next;
    end

endmodule

`default_nettype wire

>>> rtl/sorted_expiry_timer_queue.sv
// Top level of the sorted expiry timer queue: request control, output register
// and the row of setq_cell slots. Depends on setq_pkg, setq_req_if, setq_rsp_if.
//
//   channel  dir  modport  contents
//   req      in   sink     func, timer_id, expire_time, payload, now_time
//   rsp      out  source   status, out_timer_id, out_payload, out_expire, last
//
// Insert and delete hold off the next request until their response is loaded;
// adjust also through its removal, then re-placement in the row. Each response
// is registered. A tick pops one due timer per cycle from the head of the row,
// up to sixteen, while the response side takes them, or answers none if none is
// due. Reset clears all slot valid bits at once, leaving the queue empty. Until
// taken, a stalled response holds row and sequencer, except adjust re-placement.
`default_nettype none

module sorted_expiry_timer_queue import setq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input wire logic    clk,
    input wire logic    rst_n,
    setq_req_if.sink    req,
    setq_rsp_if.source  rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_TICK  = 2'd2;
    localparam logic [1:0] S_REINS = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [FUNC_W-1:0]   func_reg;
    logic [ID_W-1:0]     key_id_reg;
    logic [TIME_W-1:0]   key_exp_reg;
    logic [PAY_W-1:0]    key_pay_reg;
    logic [PAY_W-1:0]    key_pay_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [PAY_W-1:0]    out_pay_reg;
    logic [TIME_W-1:0]   out_exp_reg;
    logic                out_last_reg;

    logic                out_load;
    logic [STATUS_W-1:0] load_status;
    logic [ID_W-1:0]     load_id;
    logic [PAY_W-1:0]    load_pay;
    logic [TIME_W-1:0]   load_exp;
    logic                load_last;
    logic                out_free;
    logic                req_take;

    logic [1:0]          cmd_op;
    cmd_t                cmd;
    entry_t              cell_q [CAPACITY];
    logic [CAPACITY-1:0] le_v;
    logic [CAPACITY-1:0] match_v;
    logic [CAPACITY-1:0] found_v;
    logic [PAY_W-1:0]    sel_pay [CAPACITY];

    logic                any_match;
    logic                full;
    logic                head_due;

    assign cmd = {cmd_op, key_exp_reg, key_id_reg, key_pay_reg};

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_le_w;
            logic   found_in_w;

            if (gi == 0)
            begin : g_head
                assign left_e     = '0;
                assign left_le_w  = 1'b1;
                assign found_in_w = 1'b0;
                assign sel_pay[gi] = match_v[gi] ? cell_q[gi].payload : '0;
            end
            else
            begin : g_body
                assign left_e     = cell_q[gi-1];
                assign left_le_w  = le_v[gi-1];
                assign found_in_w = found_v[gi-1];
                assign sel_pay[gi] = sel_pay[gi-1] |
                                     (match_v[gi] ? cell_q[gi].payload : '0);
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cell_q[gi+1];
            end

            setq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .left      (left_e),
                .left_le   (left_le_w),
                .found_in  (found_in_w),
                .right     (right_e),
                .cur       (cell_q[gi]),
                .le        (le_v[gi]),
                .match     (match_v[gi]),
                .found_out (found_v[gi])
            );
        end
    endgenerate

    assign any_match = found_v[CAPACITY-1];
    assign full      = cell_q[CAPACITY-1].valid;
    // During a tick the key holds the current time, so le marks due entries.
    assign head_due  = le_v[0];

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign req_take  = req.valid && req.ready;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        key_pay_next = key_pay_reg;
        cmd_op       = CMD_HOLD;
        out_load     = 1'b0;
        load_status  = ST_DONE;
        load_id      = key_id_reg;
        load_pay     = '0;
        load_exp     = '0;
        load_last    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    state_next   = (req.func == FUNC_TICK) ? S_TICK : S_EXEC;
                    cnt_next     = '0;
                    key_pay_next = req.payload;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    case (func_reg)
                        FUNC_INSERT:
                        begin
                            if (any_match)
                            begin
                                load_status = ST_DUP;
                            end
                            else if (full)
                            begin
                                load_status = ST_FULL;
                            end
                            else
                            begin
                                cmd_op = CMD_INSERT;
                            end
                        end
                        FUNC_ADJUST:
                        begin
                            if (!any_match)
                            begin
                                load_status = ST_NOTFOUND;
                            end
                            else
                            begin
                                cmd_op       = CMD_REMOVE;
                                key_pay_next = sel_pay[CAPACITY-1];
                                state_next   = S_REINS;
                            end
                        end
                        default:
                        begin
                            if (!any_match)
                            begin
                                load_status = ST_NOTFOUND;
                            end
                            else
                            begin
                                cmd_op = CMD_REMOVE;
                            end
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (head_due)
                    begin
                        cmd_op      = CMD_POP;
                        load_status = ST_EXPIRED;
                        load_id     = cell_q[0].id;
                        load_pay    = cell_q[0].payload;
                        load_exp    = cell_q[0].expire;
                        load_last   = (cnt_reg == CNT_W'(RESULT_LIMIT - 1)) || !le_v[1];
                        cnt_next    = cnt_reg + 1'b1;
                        if (load_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        load_status = ST_NONE;
                        load_id     = '0;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                // Second half of an adjust: the row now has room for the timer.
                cmd_op     = CMD_INSERT;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_pay_reg <= key_pay_next;
        if (req_take)
        begin
            func_reg    <= req.func;
            key_id_reg  <= req.timer_id;
            key_exp_reg <= (req.func == FUNC_TICK) ? req.now_time : req.expire_time;
        end
        if (out_load)
        begin
            status_reg   <= load_status;
            out_id_reg   <= load_id;
            out_pay_reg  <= load_pay;
            out_exp_reg  <= load_exp;
            out_last_reg <= load_last;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_timer_id = out_id_reg;
    assign rsp.out_payload  = out_pay_reg;
    assign rsp.out_expire   = out_exp_reg;
    assign rsp.last         = out_last_reg;

endmodule

`default_nettype wire
